[hdl/asae_pkg.sv]
`timescale 1ns / 1ps

package asae_pkg;

	// Block size. The channel field of the beats is fixed at 3 bits.
	localparam int CHANNELS    = 8;
	localparam int SAMPLES     = 8;
	localparam int STORE_DEPTH = CHANNELS * SAMPLES;

	localparam int CH_W    = 3;
	localparam int SLOT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(SAMPLES + 1);
	localparam int VAL_W   = 10;
	localparam int SUM_W   = VAL_W + CNT_W;

	// Arithmetic constants of the average and the scaled answer.
	localparam int SCALE_FULL  = 1000;
	localparam int LIMIT_BOUND = 1024;
	localparam int FRAC_SH     = 2 + 1;
	localparam int ROUND_HALF  = 1 << 2;

	// Shared divider operand widths.
	localparam int DIVD_W    = 20;
	localparam int DIVS_W    = 10;
	localparam int DIV_CNT_W = $clog2(DIVD_W);

	// Stream widths.
	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_CONV  = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_RAW   = 2'd0,
		MODE_AVG   = 2'd1,
		MODE_CLAMP = 2'd2,
		MODE_SCALE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_ACC,
		ST_DIV_AVG,
		ST_SCALE_MUL,
		ST_SCALE_GO,
		ST_DIV_SCALE,
		ST_FINISH
	} state_t;

	// Input data beat, last field in the lowest bits.
	typedef struct packed {
		logic [6:0]       pad;
		mode_t            query_mode;
		logic [15:0]      high_limit;
		logic [VAL_W-1:0] low_limit;
		logic [7:0]       window;
		logic [CH_W-1:0]  query_channel;
		logic [VAL_W-1:0] sample_value;
		logic [7:0]       channel_mask;
	} in_beat_t;

	// Result beat, last field in the lowest bits.
	typedef struct packed {
		logic             status;
		logic [VAL_W-1:0] value;
		logic             busy_res;
		logic             scan_done;
		logic [CH_W-1:0]  convert_channel;
		logic             convert_start;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hdl/asae_ram.sv]
`timescale 1ns / 1ps

module asae_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/asae_div.sv]
`timescale 1ns / 1ps

module asae_div
	import asae_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    dsr_q;

	logic [DIVS_W:0]      trial;
	logic [DIVS_W:0]      diff;
	logic                 fits;
	logic [DIVS_W-1:0]    rem_next;

	// One restoring step: shift in the next dividend bit and try the subtract.
	always_comb begin
		trial    = {rem_q, quo_q[DIVD_W-1]};
		diff     = trial - {1'b0, dsr_q};
		fits     = (trial >= {1'b0, dsr_q});
		rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
	end

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend register shifts out its bits and fills with quotient bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[hdl/adc_scan_average_engine.sv]
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tuser: action; tdata: mask, sample, query channel, window,
//                      low limit, high limit, query mode
// m_axis    out        tdata: convert start, convert channel, scan done, busy,
//                      value, status
//
// One result beat for every input beat. A query reads its history entries one
// at a time through the store's read port; an averaging query then makes one
// pass through the shared bit-serial divider, and a scaled query adds a second
// pass through that divider. Reset clears the scan state and marks every
// history entry as zero at once. A stalled result sits in the output register
// while the next input beat is taken.

module adc_scan_average_engine
	import asae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// channel_mask[7:0], sample_value[17:8], query_channel[20:18], window[28:21],
	// low_limit[38:29], high_limit[54:39], query_mode[56:55], zeros above
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// action[1:0]
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// convert_start[0], convert_channel[3:1], scan_done[4], busy_res[5],
	// value[15:6], status[16], zeros above
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	state_t                state_q, state_d;
	action_t               act_q;
	in_beat_t              in_q;

	logic [SLOT_W-1:0]     slot_q;
	logic [CH_W-1:0]       scan_ch_q;
	logic [CHANNELS-1:0]   scan_mask_q;
	logic                  scanning_q;
	logic [STORE_DEPTH-1:0] valid_q;

	logic [SLOT_W-1:0]     rd_slot_q;
	logic [CNT_W-1:0]      rd_left_q;
	logic [SUM_W-1:0]      sum_q;
	logic [VAL_W-1:0]      avg_q;
	logic [DIVD_W-1:0]     prod_q;
	logic                  rd_ok_s1;
	result_t               res_q;
	result_t               out_q;
	logic                  out_valid_q;

	logic [SLOT_W-1:0]     newest_slot;
	logic [SLOT_W-1:0]     slot_next;
	int                    start_ch;
	int                    conv_ch;
	logic                  start_found;
	logic                  conv_found;
	logic                  qch_ok;
	logic                  win_ok;
	logic                  range_ok;
	logic                  query_go;
	logic [VAL_W-1:0]      hi10;
	logic [VAL_W-1:0]      span;
	logic [VAL_W-1:0]      rd_data;
	logic [SUM_W-1:0]      sum_next;
	logic [DIVD_W-1:0]     avg_full;
	logic [VAL_W-1:0]      avg_val;
	logic [VAL_W-1:0]      clamped;
	logic [DIVD_W-1:0]     prod_d;
	logic                  out_load;
	result_t               res_exec;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [VAL_W-1:0]      ram_rdata;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	// Lowest set mask bit at or above the starting channel, CHANNELS if none.
	function automatic int next_chan(input logic [CHANNELS-1:0] mask, input int from);
		int found;
		found = CHANNELS;
		for (int c = CHANNELS - 1; c >= 0; c--) begin
			if (mask[c] && (c >= from)) begin
				found = c;
			end
		end
		return found;
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [CH_W-1:0] ch,
			input logic [SLOT_W-1:0] slot);
		return ADDR_W'(int'(ch) * SAMPLES + int'(slot));
	endfunction

	// Scan and query decode.
	always_comb begin
		newest_slot = (slot_q == '0) ? SLOT_W'(SAMPLES - 1) : slot_q - 1'b1;
		slot_next   = (slot_q == SLOT_W'(SAMPLES - 1)) ? '0 : slot_q + 1'b1;
		start_ch    = next_chan(in_q.channel_mask[CHANNELS-1:0], 0);
		conv_ch     = next_chan(scan_mask_q, int'(scan_ch_q) + 1);
		start_found = (start_ch < CHANNELS);
		conv_found  = (conv_ch < CHANNELS);
		qch_ok      = (int'(in_q.query_channel) < CHANNELS);
		win_ok      = (in_q.window != '0) && (int'(in_q.window) <= SAMPLES);
		range_ok    = (in_q.high_limit > {6'd0, in_q.low_limit}) &&
		              (in_q.high_limit < 16'(LIMIT_BOUND));
		query_go    = qch_ok && ((in_q.query_mode == MODE_RAW) ||
		              (win_ok && ((in_q.query_mode == MODE_AVG) || range_ok)));
		hi10        = in_q.high_limit[VAL_W-1:0];
		span        = hi10 - in_q.low_limit;
	end

	// Result fields that are settled when the beat executes.
	always_comb begin
		res_exec = '0;
		if (act_q == ACT_START) begin
			res_exec.convert_start   = start_found;
			res_exec.convert_channel = start_found ? CH_W'(start_ch) : '0;
			res_exec.scan_done       = !start_found;
			res_exec.busy_res        = start_found;
		end else if ((act_q == ACT_CONV) && scanning_q) begin
			res_exec.convert_start   = conv_found;
			res_exec.convert_channel = conv_found ? CH_W'(conv_ch) : '0;
			res_exec.scan_done       = !conv_found;
			res_exec.busy_res        = conv_found;
		end else if (act_q == ACT_QUERY) begin
			res_exec.busy_res = scanning_q;
			res_exec.status   = !query_go;
		end
	end

	// History read, accumulation, rounding, clamp and scale product.
	always_comb begin
		rd_data  = rd_ok_s1 ? ram_rdata : '0;
		sum_next = sum_q + SUM_W'(rd_data);
		avg_full = div_rsp.quotient + DIVD_W'(ROUND_HALF);
		avg_val  = avg_full[FRAC_SH +: VAL_W];
		if (avg_val > hi10) begin
			clamped = hi10;
		end else if (avg_val < in_q.low_limit) begin
			clamped = in_q.low_limit;
		end else begin
			clamped = avg_val;
		end
		prod_d = DIVD_W'(SCALE_FULL) * DIVD_W'(avg_q - in_q.low_limit);
	end

	// Store ports and divider requests.
	always_comb begin
		ram_we    = (state_q == ST_EXEC) && (act_q == ACT_CONV) && scanning_q;
		ram_waddr = store_addr(scan_ch_q, slot_q);
		ram_raddr = store_addr(in_q.query_channel, rd_slot_q);

		div_req.start = ((state_q == ST_ACC) && (rd_left_q == '0) &&
		                (in_q.query_mode != MODE_RAW)) || (state_q == ST_SCALE_GO);
		if (state_q == ST_SCALE_GO) begin
			div_req.dividend = prod_q;
			div_req.divisor  = span;
		end else begin
			div_req.dividend = DIVD_W'(sum_next) << FRAC_SH;
			div_req.divisor  = DIVS_W'(in_q.window);
		end
	end

	asae_ram #(
		.WIDTH(VAL_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(in_q.sample_value),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	asae_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d  = state_q;
		out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if ((act_q == ACT_QUERY) && query_go) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (rd_left_q != '0) begin
					state_d = ST_READ;
				end else if (in_q.query_mode == MODE_RAW) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DIV_AVG;
				end
			end
			ST_DIV_AVG: begin
				if (div_rsp.done) begin
					state_d = (in_q.query_mode == MODE_SCALE) ? ST_SCALE_MUL : ST_FINISH;
				end
			end
			ST_SCALE_MUL: begin
				state_d = ST_SCALE_GO;
			end
			ST_SCALE_GO: begin
				state_d = ST_DIV_SCALE;
			end
			ST_DIV_SCALE: begin
				if (div_rsp.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Scan state, entry valid bits and the output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			scan_ch_q   <= '0;
			scan_mask_q <= '0;
			scanning_q  <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EXEC) begin
				unique case (act_q)
					ACT_START: begin
						if (start_found) begin
							scan_mask_q <= in_q.channel_mask[CHANNELS-1:0];
							scanning_q  <= 1'b1;
							scan_ch_q   <= CH_W'(start_ch);
						end else begin
							scan_mask_q <= '0;
							scanning_q  <= 1'b0;
							scan_ch_q   <= '0;
						end
					end
					ACT_CONV: begin
						if (scanning_q) begin
							valid_q[ram_waddr] <= 1'b1;
							if (conv_found) begin
								scan_ch_q <= CH_W'(conv_ch);
							end else begin
								scanning_q  <= 1'b0;
								scan_ch_q   <= '0;
								scan_mask_q <= '0;
								slot_q      <= slot_next;
							end
						end
					end
					ACT_QUERY: begin
					end
					ACT_CLEAR: begin
						valid_q     <= '0;
						slot_q      <= '0;
						scan_ch_q   <= '0;
						scan_mask_q <= '0;
						scanning_q  <= 1'b0;
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured beat, query walk and result assembly.
	always_ff @(posedge clk) begin
		rd_ok_s1 <= valid_q[ram_raddr];
		if ((state_q == ST_IDLE) && s_axis_tvalid) begin
			in_q  <= in_beat_t'(s_axis_tdata);
			act_q <= action_t'(s_axis_tuser);
		end
		unique case (state_q)
			ST_EXEC: begin
				res_q     <= res_exec;
				rd_slot_q <= newest_slot;
				sum_q     <= '0;
				rd_left_q <= (in_q.query_mode == MODE_RAW) ? CNT_W'(1) : CNT_W'(in_q.window);
			end
			ST_READ: begin
				rd_slot_q <= (rd_slot_q == '0) ? SLOT_W'(SAMPLES - 1) : rd_slot_q - 1'b1;
				rd_left_q <= rd_left_q - 1'b1;
			end
			ST_ACC: begin
				sum_q <= sum_next;
				if (in_q.query_mode == MODE_RAW) begin
					res_q.value <= rd_data;
				end
			end
			ST_DIV_AVG: begin
				if (div_rsp.done) begin
					res_q.value <= (in_q.query_mode == MODE_AVG) ? avg_val : clamped;
					avg_q       <= clamped;
				end
			end
			ST_SCALE_MUL: begin
				prod_q <= prod_d;
			end
			ST_DIV_SCALE: begin
				if (div_rsp.done) begin
					res_q.value <= div_rsp.quotient[VAL_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_q};

	// A running scan always points at a channel of its own mask.
	a_scan_ch_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		scanning_q |-> scan_mask_q[scan_ch_q])
		else $error("scan channel is not in the scan mask");

	// Without a scan no mask is left behind.
	a_idle_mask_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!scanning_q |-> (scan_mask_q == '0))
		else $error("scan mask left set while idle");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> ((state_q == ST_DIV_AVG) || (state_q == ST_DIV_SCALE)))
		else $error("divider finished outside a divide state");

	// A finished item with a free output register is presented next cycle.
	a_finish_presents: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && !out_valid_q) |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("finished result was not presented");

endmodule

[tb/adc_scan_checker.sv]
`timescale 1ns / 1ps

module adc_scan_checker
	import asae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int REPORT_LIMIT = 10;

	// Own copy of the scan state and the sample history.
	logic [VAL_W-1:0] history [CHANNELS][SAMPLES];
	int unsigned      slot;
	int unsigned      scan_ch;
	logic [7:0]       scan_mask;
	logic             scanning;

	result_t          awaited_results [$];
	int               fail_total;

	// Lowest masked channel at or above the given one, CHANNELS if none is left.
	function automatic int unsigned first_channel(int unsigned from);
		int unsigned c;
		for (c = from; c < CHANNELS; c++) begin
			if (scan_mask[c])
				return c;
		end
		return CHANNELS;
	endfunction

	// Rounded mean of the newest w samples of one channel, walking back with wrap.
	function automatic int unsigned window_mean(int unsigned ch, int unsigned w);
		int unsigned total, newest, i;
		total = 0;
		newest = (slot + SAMPLES - 1) % SAMPLES;
		for (i = 0; i < w; i++)
			total += history[ch][(newest + SAMPLES - i) % SAMPLES];
		return (((total << FRAC_SH) / w) + ROUND_HALF) >> FRAC_SH;
	endfunction

	// Apply one accepted beat to the state and return the response it causes.
	function automatic result_t predict_response(action_t act, in_beat_t b);
		result_t     r;
		int unsigned c, w, lo, hi, mean;
		r = '0;
		w = b.window;
		lo = b.low_limit;
		hi = b.high_limit;
		case (act)
			ACT_START: begin
				scan_mask = b.channel_mask & 8'((1 << CHANNELS) - 1);
				c = first_channel(0);
				if (c < CHANNELS) begin
					scanning = 1'b1;
					scan_ch = c;
					r.convert_start = 1'b1;
					r.convert_channel = CH_W'(c);
				end else begin
					// Nothing to convert: the scan ends at once, slot unchanged.
					scanning = 1'b0;
					scan_ch = 0;
					scan_mask = '0;
					r.scan_done = 1'b1;
				end
			end
			ACT_CONV: begin
				if (scanning) begin
					history[scan_ch][slot] = b.sample_value;
					c = first_channel(scan_ch + 1);
					if (c < CHANNELS) begin
						scan_ch = c;
						r.convert_start = 1'b1;
						r.convert_channel = CH_W'(c);
					end else begin
						scanning = 1'b0;
						scan_ch = 0;
						scan_mask = '0;
						slot = (slot + 1) % SAMPLES;
						r.scan_done = 1'b1;
					end
				end
			end
			ACT_QUERY: begin
				if (b.query_channel >= CHANNELS) begin
					r.status = 1'b1;
				end else if (b.query_mode == MODE_RAW) begin
					r.value = history[b.query_channel][(slot + SAMPLES - 1) % SAMPLES];
				end else if (w == 0 || w > SAMPLES) begin
					r.status = 1'b1;
				end else if (b.query_mode == MODE_AVG) begin
					r.value = VAL_W'(window_mean(b.query_channel, w));
				end else if (!(hi > lo && hi < LIMIT_BOUND)) begin
					r.status = 1'b1;
				end else begin
					mean = window_mean(b.query_channel, w);
					if (mean > hi)
						mean = hi;
					else if (mean < lo)
						mean = lo;
					if (b.query_mode == MODE_CLAMP)
						r.value = VAL_W'(mean);
					else
						r.value = VAL_W'((SCALE_FULL * (mean - lo)) / (hi - lo));
				end
			end
			default: begin
				// Clear wipes the history and drops any scan.
				foreach (history[i, j])
					history[i][j] = '0;
				slot = 0;
				scan_ch = 0;
				scan_mask = '0;
				scanning = 1'b0;
			end
		endcase
		r.busy_res = scanning;
		return r;
	endfunction

	// Predict on every input beat and compare every result beat in order.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got, want;
		logic    bad;
		if (!arst_n) begin
			foreach (history[i, j])
				history[i][j] = '0;
			slot = 0;
			scan_ch = 0;
			scan_mask = '0;
			scanning = 1'b0;
			awaited_results.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				awaited_results.push_back(predict_response(action_t'(s_tuser),
					in_beat_t'(s_tdata)));
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (awaited_results.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("%0t: result beat with nothing expected: %h", $realtime,
							m_tdata);
				end else begin
					want = awaited_results.pop_front();
					bad = (got.convert_start != want.convert_start) ||
						(got.convert_channel != want.convert_channel) ||
						(got.scan_done != want.scan_done) ||
						(got.busy_res != want.busy_res) ||
						(got.value != want.value) ||
						(got.status != want.status);
					if (bad) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT)
							$display({"%0t: mismatch: expected start %0d ch %0d done %0d ",
								"busy %0d value %0d status %0d, got start %0d ch %0d ",
								"done %0d busy %0d value %0d status %0d"}, $realtime,
								want.convert_start, want.convert_channel, want.scan_done,
								want.busy_res, want.value, want.status,
								got.convert_start, got.convert_channel, got.scan_done,
								got.busy_res, got.value, got.status);
					end
				end
			end
			mismatches <= fail_total;
			outstanding <= awaited_results.size();
		end
	end

endmodule

[tb/adc_scan_average_engine_tb.sv]
`timescale 1ns / 1ps

module adc_scan_average_engine_tb;
	import asae_pkg::*;

	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_LIMIT = 200;
	localparam int PHASE_ITEMS  = 310;
	localparam int HOLD_CYCLES  = 400;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int items_sent;
	int cycles = 0;

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	adc_scan_average_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	adc_scan_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.s_tuser     (s_axis_tuser),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("adc_scan_average_engine_tb: FAIL");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Fully random beat with the padding cleared.
	function automatic in_beat_t rand_beat();
		in_beat_t b;
		b = {$urandom, $urandom};
		b.pad = '0;
		return b;
	endfunction

	function automatic in_beat_t start_beat(logic [7:0] mask);
		in_beat_t b;
		b = rand_beat();
		b.channel_mask = mask;
		return b;
	endfunction

	function automatic in_beat_t conv_beat(logic [VAL_W-1:0] sample);
		in_beat_t b;
		b = rand_beat();
		b.sample_value = sample;
		return b;
	endfunction

	function automatic in_beat_t query_beat(logic [CH_W-1:0] ch, mode_t mode,
		logic [7:0] w, logic [VAL_W-1:0] lo, logic [15:0] hi);
		in_beat_t b;
		b = rand_beat();
		b.query_channel = ch;
		b.query_mode = mode;
		b.window = w;
		b.low_limit = lo;
		b.high_limit = hi;
		return b;
	endfunction

	// Offer one beat after a random gap and hold it until it is taken.
	task automatic send_beat(action_t act, in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Stop offering beats until every result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Query with mostly valid windows and ranges, the rest anything the fields allow.
	task automatic random_query();
		logic [7:0]       w;
		logic [VAL_W-1:0] lo;
		logic [15:0]      hi;
		w = ($urandom_range(99) < 85) ? 8'($urandom_range(SAMPLES, 1)) : 8'($urandom);
		if ($urandom_range(99) < 75) begin
			lo = VAL_W'($urandom_range(LIMIT_BOUND - 2));
			hi = 16'($urandom_range(LIMIT_BOUND - 1, lo + 1));
		end else begin
			lo = VAL_W'($urandom);
			hi = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(LIMIT_BOUND - 1));
		end
		send_beat(ACT_QUERY, query_beat(CH_W'($urandom), mode_t'($urandom_range(3)),
			w, lo, hi));
		items_sent++;
	endtask

	// A scan with one conversion per masked channel; sometimes queried mid-way
	// or cut short, leaving the next start to abandon it.
	task automatic random_scan();
		logic [7:0] mask;
		int         n, count, roll;
		mask = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom);
		send_beat(ACT_START, start_beat(mask));
		items_sent++;
		count = $countones(mask);
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 4)
				return;
			if (roll < 15)
				random_query();
			send_beat(ACT_CONV, conv_beat(VAL_W'($urandom)));
			items_sent++;
		end
	endtask

	task automatic random_items(int amount);
		int goal, roll;
		goal = items_sent + amount;
		while (items_sent < goal) begin
			roll = $urandom_range(99);
			if (roll < 42) begin
				random_scan();
			end else if (roll < 90) begin
				random_query();
			end else if (roll < 97) begin
				// Stray conversion, usually ignored by an idle block.
				send_beat(ACT_CONV, conv_beat(VAL_W'($urandom)));
				items_sent++;
			end else begin
				send_beat(ACT_CLEAR, rand_beat());
				items_sent++;
			end
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		items_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Freshly reset store, a conversion while idle, and an empty mask.
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_RAW, 8'd0, 10'd0, 16'd0));
		send_beat(ACT_CONV, conv_beat(10'h3FF));
		send_beat(ACT_START, start_beat(8'h00));

		// Full scan with extreme samples on the first two channels.
		send_beat(ACT_START, start_beat(8'hFF));
		for (i = 0; i < CHANNELS; i++)
			send_beat(ACT_CONV, conv_beat((i == 0) ? 10'h3FF : (i == 1) ? 10'h000 :
				VAL_W'($urandom)));

		// A restart abandons the running scan in the same slot.
		send_beat(ACT_START, start_beat(8'h81));
		send_beat(ACT_CONV, conv_beat(10'h155));
		send_beat(ACT_START, start_beat(8'h02));
		send_beat(ACT_CONV, conv_beat(10'h2AA));

		// Every query mode, with bad windows and bad ranges.
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_RAW, 8'd255, 10'h3FF, 16'hFFFF));
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_AVG, 8'd8, 10'd0, 16'd0));
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_AVG, 8'd0, 10'd0, 16'd1023));
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_CLAMP, 8'd255, 10'd0, 16'd1023));
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_CLAMP, 8'd2, 10'd500, 16'd500));
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_SCALE, 8'd2, 10'd0, 16'hFFFF));
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_CLAMP, 8'd1, 10'd100, 16'd200));
		send_beat(ACT_QUERY, query_beat(3'd1, MODE_SCALE, 8'd2, 10'd0, 16'd1023));

		// Clear, then read back zero.
		send_beat(ACT_CLEAR, rand_beat());
		send_beat(ACT_QUERY, query_beat(3'd0, MODE_RAW, 8'd1, 10'd0, 16'd1));
		drain();

		// No idling, opened by a long result hold-off that backs up the input.
		hold_request = HOLD_CYCLES;
		random_items(PHASE_ITEMS);
		drain();

		send_idle_pct = 50;
		random_items(PHASE_ITEMS);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 50;
		random_items(PHASE_ITEMS);
		drain();

		send_idle_pct = 11;
		recv_stall_pct = 11;
		random_items(PHASE_ITEMS);
		drain();

		repeat (SETTLE_LIMIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("adc_scan_average_engine_tb: PASS");
		else
			$display("adc_scan_average_engine_tb: FAIL");
		$finish;
	end

endmodule
